FILE: rtl/core/sidmp_pkg.sv
// ----------------------------------------------------------------------------
// sidmp_pkg
// Shared types and constants of the split instruction/data memory port.
// ----------------------------------------------------------------------------
package sidmp_pkg;

   localparam int BANKS = 4;
   localparam logic [31:0] DATA_BASE_RESET = 32'h1000_0000;
   localparam logic [2:0] MAX_BYTES = 3'd4;

   typedef enum logic [1:0] {
      OP_FETCH   = 2'd0,
      OP_LOAD    = 2'd1,
      OP_STORE   = 2'd2,
      OP_PRELOAD = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_OK           = 2'd0,
      RS_WRONG_REGION = 2'd1,
      RS_EMPTY        = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WAIT
   } state_type;

endpackage

FILE: rtl/core/sidmp_data_banks.sv
// ----------------------------------------------------------------------------
// sidmp_data_banks
// Four byte-wide data banks, one write and one registered read per bank.
// ----------------------------------------------------------------------------
module sidmp_data_banks #(
   parameter int ROWS = 1024,
   localparam int RW = $clog2(ROWS)
) (
   input  logic                                 clock,
   input  logic [sidmp_pkg::BANKS-1:0]          wr_en,
   input  logic [sidmp_pkg::BANKS-1:0][RW-1:0]  row,
   input  logic [sidmp_pkg::BANKS-1:0][7:0]     wr_byte,
   output logic [sidmp_pkg::BANKS-1:0][7:0]     rd_byte
);
   import sidmp_pkg::*;

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [7:0] mem [ROWS];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en[b]) begin
            mem[row[b]] <= wr_byte[b];
         end
         rd_ff <= mem[row[b]];
      end

      assign rd_byte[b] = rd_ff;
   end

endmodule

FILE: rtl/core/split_instruction_data_memory_port_unit.sv
// ----------------------------------------------------------------------------
// split_instruction_data_memory_port_unit
// Memory port with an instruction region below data_base and a data region
// at or above it.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the data banks and
// the instruction valid marks; req_tready stays low meanwhile. A store, a
// preload or a wrong-region access is answered from S_IDLE straight into the
// output register; a load or a fetch passes through S_WAIT, as the data banks
// and the instruction memory have a registered read, followed for a load by
// lane assembly. The data store is split into four byte banks so that any 1
// to 4 byte access, aligned or not, touches each bank at most once. DATA_DEPTH
// and INSTR_DEPTH must be powers of two. Results are held in an output register.
// ----------------------------------------------------------------------------
module split_instruction_data_memory_port_unit #(
   parameter int DATA_DEPTH  = 4096,
   parameter int INSTR_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // address[31:0], byte_count[34:32], write_data[66:35]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_data[31:0]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import sidmp_pkg::*;

   localparam int DIDX    = $clog2(DATA_DEPTH);
   localparam int DROWS   = DATA_DEPTH / BANKS;
   localparam int RW      = DIDX - 2;
   localparam int IIDX    = $clog2(INSTR_DEPTH);
   localparam int CLR_LEN = (DROWS > INSTR_DEPTH) ? DROWS : INSTR_DEPTH;
   localparam int CW      = $clog2(CLR_LEN);

   state_type   state_ff, state_in;
   logic [31:0] data_base_ff;
   logic [CW-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [1:0]  lane_ff;
   logic [2:0]  ncnt_ff;
   logic        fetch_ff;

   op_type      op;
   logic [31:0] addr;
   logic [2:0]  cnt;
   logic [2:0]  nclip;
   logic [31:0] wdata;
   logic        in_data;
   logic        accept;
   logic        bad_region;
   logic        clr_data;
   logic        clr_instr;

   logic [BANKS-1:0]         bank_we;
   logic [BANKS-1:0][RW-1:0] bank_row;
   logic [BANKS-1:0][7:0]    bank_wbyte;
   logic [BANKS-1:0][7:0]    bank_rd;

   logic [32:0]     imem [INSTR_DEPTH];
   logic [32:0]     ird_ff;
   logic            imem_we;
   logic [IIDX-1:0] imem_addr;
   logic [32:0]     imem_wdata;
   logic [IIDX-1:0] slot;

   logic [31:0] load_val;

   assign op      = op_type'(req_tuser);
   assign addr    = req_tdata[31:0];
   assign cnt     = req_tdata[34:32];
   assign wdata   = req_tdata[66:35];
   assign nclip   = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
   assign in_data = addr >= data_base_ff;
   assign slot    = addr[2 +: IIDX];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign clr_data  = (state_ff == S_CLEAR) && ({1'b0, clr_ff} < (CW + 1)'(DROWS));
   assign clr_instr = (state_ff == S_CLEAR) && ({1'b0, clr_ff} < (CW + 1)'(INSTR_DEPTH));

   always_comb begin
      unique case (op)
         OP_FETCH, OP_PRELOAD: bad_region = in_data;
         OP_LOAD, OP_STORE:    bad_region = !in_data;
         default:              bad_region = 1'b1;
      endcase
   end

   // byte k of the access lands in bank (addr + k) mod 4
   always_comb begin
      logic [1:0]      k;
      logic [DIDX-1:0] a;
      for (int b = 0; b < BANKS; b++) begin
         k = 2'(b) - addr[1:0];
         a = addr[DIDX-1:0] + DIDX'(k);
         if (clr_data) begin
            bank_we[b]    = 1'b1;
            bank_row[b]   = clr_ff[RW-1:0];
            bank_wbyte[b] = 8'h00;
         end else begin
            bank_we[b]    = accept && (op == OP_STORE) && in_data && ({1'b0, k} < nclip);
            bank_row[b]   = a[DIDX-1:2];
            bank_wbyte[b] = wdata[8*k +: 8];
         end
      end
   end

   sidmp_data_banks #(
      .ROWS(DROWS)
   ) u_data_banks (
      .clock   (clock),
      .wr_en   (bank_we),
      .row     (bank_row),
      .wr_byte (bank_wbyte),
      .rd_byte (bank_rd)
   );

   always_comb begin
      if (clr_instr) begin
         imem_we    = 1'b1;
         imem_addr  = clr_ff[IIDX-1:0];
         imem_wdata = 33'd0;
      end else begin
         imem_we    = accept && (op == OP_PRELOAD) && !in_data;
         imem_addr  = slot;
         imem_wdata = {1'b1, wdata};
      end
   end

   always_ff @(posedge clock) begin
      if (imem_we) begin
         imem[imem_addr] <= imem_wdata;
      end
      ird_ff <= imem[slot];
   end

   always_comb begin
      logic [7:0] bv;
      load_val = 32'd0;
      for (int k = 0; k < BANKS; k++) begin
         bv = bank_rd[2'(lane_ff + 2'(k))];
         if (3'(k) < ncnt_ff) begin
            load_val[8*k +: 8] = bv;
         end
      end
      unique case (ncnt_ff)
         3'd1:    load_val = {{24{load_val[7]}}, load_val[7:0]};
         3'd2:    load_val = {{16{load_val[15]}}, load_val[15:0]};
         3'd3:    load_val = {{8{load_val[23]}}, load_val[23:0]};
         default: load_val = load_val;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(CLR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (!bad_region && (op == OP_FETCH || op == OP_LOAD)) begin
                  state_in = S_WAIT;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 32'd0;
                  rsp_status_in = bad_region ? RS_WRONG_REGION : RS_OK;
               end
            end
         end
         S_WAIT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (fetch_ff) begin
               rsp_data_in   = ird_ff[32] ? ird_ff[31:0] : 32'd0;
               rsp_status_in = ird_ff[32] ? RS_OK : RS_EMPTY;
            end else begin
               rsp_data_in   = load_val;
               rsp_status_in = RS_OK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         data_base_ff <= DATA_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            data_base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         lane_ff  <= addr[1:0];
         ncnt_ff  <= nclip;
         fetch_ff <= (op == OP_FETCH);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
